// ===== hdl/gwwb_pkg.sv =====
package gwwb_pkg;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 27;
  localparam int TOT_W   = SUM_W + 2;   // B+G+R and 3*channel both fit here
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = $clog2(GAIN_W);

  localparam logic [SUM_W-1:0]  SUM_FIELD_MAX = '1;
  localparam logic [GAIN_W-1:0] GAIN_MAX      = '1;
  localparam logic [STEP_W-1:0] LAST_STEP     = STEP_W'(GAIN_W - 1);

  localparam logic CMD_STATS = 1'b0;
  localparam logic CMD_APPLY = 1'b1;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_START,
    ST_ITER,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic  acc;        // add pixel into channel sums
    logic  load_out;   // capture scaled pixel into output register
    logic  div_start;  // load divider for channel ch
    logic  div_step;   // one restoring division step
    logic  gain_wr;    // write quotient into gain of channel ch
    logic  sum_clr;    // clear channel sums
    chan_t ch;
  } ctrl_cmd_t;

endpackage

// ===== hdl/gwwb_ctrl.sv =====
module gwwb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_cmd,
  input  logic                  in_last,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output gwwb_pkg::ctrl_cmd_t   cmd
);

  gwwb_pkg::state_t              state_r, state_nxt;
  gwwb_pkg::chan_t               ch_r, ch_nxt;
  logic [gwwb_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          in_acc;

  assign out_tvalid = out_valid_r;
  assign in_acc     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gwwb_pkg::ST_RUN;
      ch_r        <= gwwb_pkg::CH_BLUE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cnt_nxt       = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.ch        = ch_r;

    case (state_r)
      gwwb_pkg::ST_RUN: begin
        // stats items never reach the output, but keep it simple: one gate
        in_tready = !out_valid_r || out_tready;
        if (in_acc) begin
          if (in_cmd == gwwb_pkg::CMD_APPLY) begin
            cmd.load_out  = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.acc = 1'b1;
            if (in_last) begin
              ch_nxt    = gwwb_pkg::CH_BLUE;
              state_nxt = gwwb_pkg::ST_START;
            end
          end
        end
      end
      gwwb_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = gwwb_pkg::ST_ITER;
      end
      gwwb_pkg::ST_ITER: begin
        cmd.div_step = 1'b1;
        if (cnt_r == gwwb_pkg::LAST_STEP) begin
          state_nxt = gwwb_pkg::ST_WRITE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gwwb_pkg::ST_WRITE: begin
        cmd.gain_wr = 1'b1;
        if (ch_r == gwwb_pkg::CH_RED) begin
          cmd.sum_clr = 1'b1;
          ch_nxt      = gwwb_pkg::CH_BLUE;
          state_nxt   = gwwb_pkg::ST_RUN;
        end else begin
          ch_nxt    = (ch_r == gwwb_pkg::CH_BLUE) ? gwwb_pkg::CH_GREEN : gwwb_pkg::CH_RED;
          state_nxt = gwwb_pkg::ST_START;
        end
      end
      default: begin
        state_nxt = gwwb_pkg::ST_RUN;
      end
    endcase
  end

  a_last_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == gwwb_pkg::CMD_STATS && in_last) |=> state_r == gwwb_pkg::ST_START)
    else $error("frame end did not start gain computation");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gwwb_pkg::ST_ITER) |-> cnt_r == '0)
    else $error("step counter left nonzero outside division");

  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r == gwwb_pkg::CH_BLUE || ch_r == gwwb_pkg::CH_GREEN || ch_r == gwwb_pkg::CH_RED)
    else $error("channel index out of range");

  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc && in_cmd == gwwb_pkg::CMD_APPLY))
    else $error("result appeared without an apply item");

endmodule

// ===== hdl/gwwb_dp.sv =====
module gwwb_dp #(
  parameter int MAX_PIXELS     = 524288,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gwwb_pkg::ctrl_cmd_t         cmd,
  input  logic [gwwb_pkg::PIX_W-1:0]  in_blue,
  input  logic [gwwb_pkg::PIX_W-1:0]  in_green,
  input  logic [gwwb_pkg::PIX_W-1:0]  in_red,
  input  logic                        in_last,
  output logic [gwwb_pkg::PIX_W-1:0]  out_blue,
  output logic [gwwb_pkg::PIX_W-1:0]  out_green,
  output logic [gwwb_pkg::PIX_W-1:0]  out_red,
  output logic                        out_last
);

  localparam int SW = gwwb_pkg::SUM_W;
  localparam int TW = gwwb_pkg::TOT_W;
  localparam int GW = gwwb_pkg::GAIN_W;
  localparam int PW = gwwb_pkg::PIX_W;
  localparam int DIV_W  = TW + GAIN_FRAC_BITS;
  localparam int PROD_W = PW + GW + 1;

  localparam longint SUM_LIM_L = longint'(MAX_PIXELS) * 255;
  localparam logic [SW-1:0] SUM_LIM =
    (SUM_LIM_L > longint'(gwwb_pkg::SUM_FIELD_MAX)) ? gwwb_pkg::SUM_FIELD_MAX
                                                      : SW'(SUM_LIM_L);
  localparam logic [GW-1:0] UNITY =
    (GAIN_FRAC_BITS >= GW) ? gwwb_pkg::GAIN_MAX : GW'(64'd1 << GAIN_FRAC_BITS);
  localparam logic [PROD_W-1:0] HALF = PROD_W'(64'd1 << (GAIN_FRAC_BITS - 1));

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                            input logic [PW-1:0] p);
    logic [SW:0] t;
    t = {1'b0, s} + (SW+1)'(p);
    return (t > {1'b0, SUM_LIM}) ? SUM_LIM : t[SW-1:0];
  endfunction

  function automatic logic [PW-1:0] scale(input logic [PW-1:0] p,
                                          input logic [GW-1:0] g);
    logic [PROD_W-1:0] s;
    logic [PROD_W-1:0] v;
    s = PROD_W'(p) * PROD_W'(g) + HALF;
    v = s >> GAIN_FRAC_BITS;
    return (v > PROD_W'(255)) ? '1 : v[PW-1:0];
  endfunction

  logic [SW-1:0] blue_sum_r, green_sum_r, red_sum_r;
  logic [GW-1:0] blue_gain_r, green_gain_r, red_gain_r;
  logic [TW-1:0] rem_r, dvs_r;
  logic [GW-1:0] qd_r;
  logic          sat_r;
  logic [PW-1:0] blue_out_r, green_out_r, red_out_r;
  logic          last_out_r;

  logic [TW-1:0]    total, divisor;
  logic [SW-1:0]    chan_sum;
  logic [DIV_W-1:0] dividend;
  logic [TW-1:0]    top;
  logic [TW:0]      trial;
  logic             ge;
  logic [GW-1:0]    gain_val;

  assign total    = TW'(blue_sum_r) + TW'(green_sum_r) + TW'(red_sum_r);
  assign dividend = {total, {GAIN_FRAC_BITS{1'b0}}};
  assign top      = TW'(dividend >> GW);

  always_comb begin
    case (cmd.ch)
      gwwb_pkg::CH_BLUE:  chan_sum = blue_sum_r;
      gwwb_pkg::CH_GREEN: chan_sum = green_sum_r;
      gwwb_pkg::CH_RED:   chan_sum = red_sum_r;
      default:            chan_sum = red_sum_r;
    endcase
  end

  assign divisor  = TW'(chan_sum) + {TW'(chan_sum) << 1};
  assign trial    = {rem_r, qd_r[GW-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  // zero channel sum lands here too: top >= 0 always
  assign gain_val = sat_r ? gwwb_pkg::GAIN_MAX : qd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blue_sum_r   <= '0;
      green_sum_r  <= '0;
      red_sum_r    <= '0;
      blue_gain_r  <= UNITY;
      green_gain_r <= UNITY;
      red_gain_r   <= UNITY;
    end else begin
      if (cmd.sum_clr) begin
        blue_sum_r  <= '0;
        green_sum_r <= '0;
        red_sum_r   <= '0;
      end else if (cmd.acc) begin
        blue_sum_r  <= sat_add(blue_sum_r, in_blue);
        green_sum_r <= sat_add(green_sum_r, in_green);
        red_sum_r   <= sat_add(red_sum_r, in_red);
      end
      if (cmd.gain_wr) begin
        case (cmd.ch)
          gwwb_pkg::CH_BLUE:  blue_gain_r  <= gain_val;
          gwwb_pkg::CH_GREEN: green_gain_r <= gain_val;
          gwwb_pkg::CH_RED:   red_gain_r   <= gain_val;
          default:            red_gain_r   <= gain_val;
        endcase
      end
    end
  end

  // shared restoring divider: high part of dividend preloads the remainder,
  // quotient bits shift into the low part one per step
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= top;
      qd_r  <= dividend[GW-1:0];
      dvs_r <= divisor;
      sat_r <= top >= divisor;
    end else if (cmd.div_step) begin
      rem_r <= ge ? TW'(trial - {1'b0, dvs_r}) : TW'(trial);
      qd_r  <= {qd_r[GW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      blue_out_r  <= scale(in_blue, blue_gain_r);
      green_out_r <= scale(in_green, green_gain_r);
      red_out_r   <= scale(in_red, red_gain_r);
      last_out_r  <= in_last;
    end
  end

  assign out_blue  = blue_out_r;
  assign out_green = green_out_r;
  assign out_red   = red_out_r;
  assign out_last  = last_out_r;

endmodule

// ===== hdl/gray_world_white_balance.sv =====
// Gray-world white balance on a BGR stream sent twice per frame. Items with
// tuser = 0 accumulate saturating per-channel sums; the one marked tlast then
// sets each gain to (B+G+R)/(3*channel) in unsigned fixed point with
// GAIN_FRAC_BITS fraction bits (16 bits total, max on overflow or zero sum)
// and clears the sums. Items with tuser = 1 are scaled by the gains, rounded
// half up, clamped to 255, and returned with tlast echoed; gains are unity
// after reset. Throughput is one item per cycle for both passes unless the
// output stalls, with the output register decoupling the sides. After the final
// statistics item the input is held off while one radix-2 restoring divider,
// shared by the three channels, runs load, 16 quotient bits and write back per gain.
module gray_world_white_balance #(
  parameter int MAX_PIXELS     = 524288,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue_out[7:0], green_out[15:8], red_out[23:16]
  output logic        out_tlast   // frame_end_out
);

  gwwb_pkg::ctrl_cmd_t cmd;

  gwwb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_last    (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gwwb_dp #(
    .MAX_PIXELS     (MAX_PIXELS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_blue   (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_red    (in_tdata[23:16]),
    .in_last   (in_tlast),
    .out_blue  (out_tdata[7:0]),
    .out_green (out_tdata[15:8]),
    .out_red   (out_tdata[23:16]),
    .out_last  (out_tlast)
  );

endmodule

// ===== bench/gray_world_white_balance_tb.sv =====
`timescale 1ns / 1ps

module gray_world_white_balance_tb;

  localparam int PIX_W          = gwwb_pkg::PIX_W;
  localparam int GAIN_W         = gwwb_pkg::GAIN_W;
  localparam int MAX_PIXELS     = 524288;
  localparam int GAIN_FRAC_BITS = 12;
  localparam longint unsigned SUM_LIMIT =
    (longint'(MAX_PIXELS) * 255 > longint'(gwwb_pkg::SUM_FIELD_MAX)) ?
    longint'(gwwb_pkg::SUM_FIELD_MAX) : longint'(MAX_PIXELS) * 255;
  localparam longint unsigned HALF_LSB  = longint'(1) << (GAIN_FRAC_BITS - 1);
  localparam bit [GAIN_W-1:0] UNITY     = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam int RANDOM_ITEMS           = 680;
  localparam int TAIL_CYCLES            = 80;
  localparam int LIMIT_CYCLES           = 400000;

  // red is the top byte, blue the bottom, matching tdata
  typedef struct packed {
    bit [PIX_W-1:0] red;
    bit [PIX_W-1:0] green;
    bit [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct {
    pixel_t pix;
    bit     last;
  } balanced_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // blue_in[7:0], green_in[15:8], red_in[23:16]
  logic        in_tuser   = 1'b0; // command
  logic        in_tlast   = 1'b0; // frame_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // blue_out[7:0], green_out[15:8], red_out[23:16]
  logic        out_tlast;         // frame_end_out

  gray_world_white_balance #(
    .MAX_PIXELS     (MAX_PIXELS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // predictor state
  longint unsigned blue_acc = 0, green_acc = 0, red_acc = 0;
  bit [GAIN_W-1:0] blue_gain = UNITY, green_gain = UNITY, red_gain = UNITY;
  balanced_t       balanced_q[$];

  bit in_steady  = 1'b0;
  bit out_steady = 1'b0;
  int fail_count      = 0;
  int results_checked = 0;
  int stats_sent      = 0;
  int apply_sent      = 0;
  int frames_closed   = 0;

  function automatic pixel_t mk_px(int b, int g, int r);
    pixel_t p;
    p.blue  = PIX_W'(b);
    p.green = PIX_W'(g);
    p.red   = PIX_W'(r);
    return p;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned acc, bit [PIX_W-1:0] v);
    longint unsigned s;
    s = acc + v;
    return (s > SUM_LIMIT) ? SUM_LIMIT : s;
  endfunction

  function automatic bit [GAIN_W-1:0] gain_of(longint unsigned total, longint unsigned chan);
    longint unsigned q;
    if (chan == 0) return gwwb_pkg::GAIN_MAX;
    q = (total << GAIN_FRAC_BITS) / (3 * chan);
    return (q > longint'(gwwb_pkg::GAIN_MAX)) ? gwwb_pkg::GAIN_MAX
                                               : q[GAIN_W-1:0];
  endfunction

  function automatic bit [PIX_W-1:0] scale_chan(bit [PIX_W-1:0] pix, bit [GAIN_W-1:0] gain);
    longint unsigned v;
    v = ((longint'(pix) * longint'(gain)) + HALF_LSB) >> GAIN_FRAC_BITS;
    return (v > 255) ? 8'd255 : v[PIX_W-1:0];
  endfunction

  function automatic void predict_pixel(logic cmd, pixel_t px, logic last);
    balanced_t       res;
    longint unsigned total;
    if (cmd == gwwb_pkg::CMD_STATS) begin
      blue_acc  = sat_sum(blue_acc, px.blue);
      green_acc = sat_sum(green_acc, px.green);
      red_acc   = sat_sum(red_acc, px.red);
      stats_sent++;
      if (last) begin
        total      = blue_acc + green_acc + red_acc;
        blue_gain  = gain_of(total, blue_acc);
        green_gain = gain_of(total, green_acc);
        red_gain   = gain_of(total, red_acc);
        blue_acc   = 0;
        green_acc  = 0;
        red_acc    = 0;
        frames_closed++;
      end
    end else begin
      res.pix.blue  = scale_chan(px.blue, blue_gain);
      res.pix.green = scale_chan(px.green, green_gain);
      res.pix.red   = scale_chan(px.red, red_gain);
      res.last      = last;
      balanced_q    = {balanced_q, res};
      apply_sent++;
    end
  endfunction

  // valid is left high after acceptance so back-to-back items keep it up
  task automatic send_pixel(logic cmd, pixel_t px, logic last);
    while (!in_steady && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= cmd;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(cmd, px, last);
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (balanced_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) out_tready <= out_steady || ($urandom_range(99) >= 11);

  task automatic report_fail(string what, balanced_t want, bit have_want);
    fail_count++;
    if (fail_count <= 10) begin
      if (have_want)
        $display("%0t %s: expected b=%0d g=%0d r=%0d last=%0b, got b=%0d g=%0d r=%0d last=%0b",
                 $realtime, what, want.pix.blue, want.pix.green, want.pix.red, want.last,
                 out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast);
      else
        $display("%0t %s: got b=%0d g=%0d r=%0d last=%0b", $realtime, what,
                 out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tlast);
    end
  endtask

  always @(posedge clk) begin : check_result
    balanced_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (balanced_q.size() == 0) begin
        want = '{pix: '0, last: 1'b0};
        report_fail("unexpected item", want, 1'b0);
      end else begin
        want = balanced_q.pop_front();
        results_checked++;
        if (out_tdata[7:0] !== want.pix.blue || out_tdata[15:8] !== want.pix.green ||
            out_tdata[23:16] !== want.pix.red || out_tlast !== want.last)
          report_fail("item mismatch", want, 1'b1);
      end
    end
  end

  // apply before any statistics uses unity gains
  task automatic test_unity_after_reset();
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(0, 0, 0), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(255, 255, 255), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(8'h55, 8'hAA, 8'h01), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(8'h80, 8'h7F, 8'hFE), 1'b1);
    pause_until_drained();
  endtask

  // every sum zero: all gains go to max
  task automatic test_zero_frame();
    send_pixel(gwwb_pkg::CMD_STATS, mk_px(0, 0, 0), 1'b1);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(255, 255, 255), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(1, 1, 1), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(0, 0, 0), 1'b1);
    pause_until_drained();
  endtask

  // blue gain normal, green overflows, red sum zero
  task automatic test_gain_limits();
    send_pixel(gwwb_pkg::CMD_STATS, mk_px(255, 1, 0), 1'b1);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(255, 255, 255), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(2, 1, 0), 1'b1);
    pause_until_drained();
  endtask

  task automatic test_short_frame();
    send_pixel(gwwb_pkg::CMD_STATS, mk_px(200, 100, 50), 1'b0);
    send_pixel(gwwb_pkg::CMD_STATS, mk_px(10, 120, 90), 1'b0);
    send_pixel(gwwb_pkg::CMD_STATS, mk_px(33, 77, 250), 1'b0);
    send_pixel(gwwb_pkg::CMD_STATS, mk_px(128, 64, 1), 1'b1);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(200, 100, 50), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(255, 255, 255), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(7, 3, 129), 1'b0);
    send_pixel(gwwb_pkg::CMD_APPLY, mk_px(128, 64, 1), 1'b1);
    pause_until_drained();
  endtask

  function automatic int chan_cap();
    case ($urandom_range(3))
      0:       return 255;
      1:       return 63;
      2:       return 3;
      default: return 0;
    endcase
  endfunction

  task automatic test_random_frames();
    int sent;
    int frame;
    int n;
    int cap_b, cap_g, cap_r;
    sent  = 0;
    frame = 0;
    while (sent < RANDOM_ITEMS) begin
      in_steady  = (frame >= 20 && frame < 32);
      out_steady = in_steady;
      if ($urandom_range(6) == 0) begin
        // noise: commands and frame ends in any order
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_pixel(logic'($urandom_range(1)),
                     mk_px($urandom_range(255), $urandom_range(255), $urandom_range(255)),
                     logic'($urandom_range(1)));
        sent += n;
      end
      cap_b = ($urandom_range(3) == 0) ? chan_cap() : 255;
      cap_g = ($urandom_range(3) == 0) ? chan_cap() : 255;
      cap_r = ($urandom_range(3) == 0) ? chan_cap() : 255;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_pixel(gwwb_pkg::CMD_STATS,
                   mk_px($urandom_range(cap_b), $urandom_range(cap_g), $urandom_range(cap_r)),
                   i == n - 1);
      sent += n;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++)
        send_pixel(gwwb_pkg::CMD_APPLY,
                   mk_px($urandom_range(255), $urandom_range(255), $urandom_range(255)),
                   (i == n - 1) && ($urandom_range(5) != 0));
      sent += n;
      if ($urandom_range(7) == 0) pause_until_drained();
      frame++;
    end
    in_steady  = 1'b0;
    out_steady = 1'b0;
    pause_until_drained();
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("gray_world_white_balance: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unity_after_reset();
    test_zero_frame();
    test_gain_limits();
    test_short_frame();
    test_random_frames();
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d statistics pixels over %0d closed frames, zero-sum and clipped gains",
             stats_sent, frames_closed);
    $display("and %0d balanced pixels, %0d checked, %0d failures",
             apply_sent, results_checked, fail_count);
    if (fail_count == 0 && balanced_q.size() == 0)
      $display("gray_world_white_balance: match");
    else
      $display("gray_world_white_balance: mismatch");
    $finish;
  end

endmodule
